// File: hw/rtl/path_target_point_search_macros.svh
// assertion macros for the path target point search checker
`ifndef PATH_TARGET_POINT_SEARCH_MACROS_SVH
`define PATH_TARGET_POINT_SEARCH_MACROS_SVH

// same-cycle implication, sampled on clk_i, quiet during reset
`define PTPS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, quiet during reset
`define PTPS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/ptps_pkg.sv
// types and constants shared by the path target point search block
package ptps_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_W        = 24;
  localparam int unsigned MEM_W          = 2 * COORD_W;
  localparam int unsigned SQ_W           = 2 * (COORD_W + 1);
  localparam int unsigned DIST_W         = SQ_W + 1;
  localparam int unsigned LA2_W          = 2 * COORD_W;
  localparam int unsigned IDX_OUT_W      = 10;
  localparam int unsigned CNT_OUT_W      = 11;

  typedef enum logic [1:0] {
    REQ_CLEAR     = 2'd0,
    REQ_APPEND    = 2'd1,
    REQ_NEAREST   = 2'd2,
    REQ_LOOKAHEAD = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WALK,
    ST_ADV_NXT,
    ST_ADV_CUR,
    ST_DONE
  } state_e;

  typedef struct packed {
    req_e                       req_type;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic        [COORD_W-1:0]  lookahead;
  } path_req_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] target_index;
    logic [CNT_OUT_W-1:0] point_count;
    status_e              status;
  } path_rsp_t;

endpackage

// File: hw/rtl/ptps_ram.sv
// generic single write, single read ram with registered read data
module ptps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/path_target_point_search.sv
// path target point search: waypoint store with nearest and lookahead query sequencer
// Items clear the path, append one waypoint, or query with a vehicle position. Clear and
// append pass from acceptance through the done state to a registered result. A query on n
// stored points streams every waypoint out of the single read port of the waypoint ram,
// one per cycle, through a two-stage squared-distance pipe. A nearest query then runs
// the advance step if a point follows the nearest one; it reads two points one after
// the other. A lookahead query instead streams forward from the nearest point. The next
// item is accepted once the result has moved to the output register. The waypoint store
// is not cleared after reset; only points below the stored count are ever read.
module path_target_point_search #(
  parameter int unsigned MAX_POINTS = ptps_pkg::MAX_POINTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ptps_pkg::path_req_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ptps_pkg::path_rsp_t out_item_o
);

  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW    = ptps_pkg::COORD_W;

  ptps_pkg::state_e state_q, state_d;
  ptps_pkg::req_e   req_q, req_d;
  ptps_pkg::status_e res_stat_q, res_stat_d;
  ptps_pkg::path_rsp_t out_q, out_d;

  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [IDX_W-1:0]             iss_q, iss_d;
  logic                         iss_on_q, iss_on_d;
  logic                         rd_v_q, rd_v_d;
  logic [IDX_W-1:0]             rd_tag_q, rd_tag_d;
  logic                         sq_v_q, sq_v_d;
  logic [IDX_W-1:0]             sq_tag_q, sq_tag_d;
  logic [ptps_pkg::SQ_W-1:0]    sqx_q, sqx_d, sqy_q, sqy_d;
  logic signed [CW-1:0]         ref_x_q, ref_x_d, ref_y_q, ref_y_d;
  logic signed [CW-1:0]         pt_x_q, pt_x_d, pt_y_q, pt_y_d;
  logic [ptps_pkg::LA2_W-1:0]   la2_q, la2_d;
  logic [ptps_pkg::DIST_W-1:0]  best_q, best_d, nxt_q, nxt_d;
  logic [IDX_W-1:0]             idx_q, idx_d, res_idx_q, res_idx_d;
  logic                         out_valid_q, out_valid_d;

  logic                         ram_we, ram_re;
  logic [ptps_pkg::MEM_W-1:0]   ram_wdata, ram_rdata;
  logic signed [CW-1:0]         rd_x, rd_y;
  logic [CW:0]                  dx, dy, adx, ady;
  logic [ptps_pkg::DIST_W-1:0]  dist_sq;
  logic                         in_acc, out_free, is_query, is_empty;
  logic                         better, tag_last, iss_last, adv_ok, walk_stop, flush;
  logic [IDX_W-1:0]             scan_idx;
  logic [31:0]                  res_idx_ext, cnt_ext;

  ptps_ram #(
    .WIDTH (ptps_pkg::MEM_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (iss_q),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ptps_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign is_query = (in_item_i.req_type == ptps_pkg::REQ_NEAREST) ||
                    (in_item_i.req_type == ptps_pkg::REQ_LOOKAHEAD);
  assign is_empty = (cnt_q == '0);

  // distance pipe, stage one: absolute differences and squares
  assign rd_x = ram_rdata[ptps_pkg::MEM_W-1:CW];
  assign rd_y = ram_rdata[CW-1:0];
  assign dx   = {rd_x[CW-1], rd_x} - {ref_x_q[CW-1], ref_x_q};
  assign dy   = {rd_y[CW-1], rd_y} - {ref_y_q[CW-1], ref_y_q};
  assign adx  = dx[CW] ? (~dx + 1'b1) : dx;
  assign ady  = dy[CW] ? (~dy + 1'b1) : dy;
  assign sqx_d = adx * adx;
  assign sqy_d = ady * ady;

  // stage two: sum
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqy_q};

  assign ram_re    = iss_on_q;
  assign iss_last  = (CNT_W'(iss_q) + CNT_W'(1)) == cnt_q;
  assign tag_last  = (CNT_W'(sq_tag_q) + CNT_W'(1)) == cnt_q;
  assign better    = (sq_tag_q == '0) || (dist_sq < best_q);
  assign scan_idx  = better ? sq_tag_q : idx_q;
  assign adv_ok    = (CNT_W'(scan_idx) + CNT_W'(1)) < cnt_q;
  assign walk_stop = !({{(ptps_pkg::DIST_W - ptps_pkg::LA2_W){1'b0}}, la2_q} > dist_sq) ||
                     tag_last;

  assign res_idx_ext = 32'(res_idx_q);
  assign cnt_ext     = 32'(cnt_q);

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      ptps_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = (is_query && !is_empty) ? ptps_pkg::ST_SCAN : ptps_pkg::ST_DONE;
        end
      end
      ptps_pkg::ST_SCAN: begin
        if (sq_v_q && tag_last) begin
          if (req_q == ptps_pkg::REQ_LOOKAHEAD) begin
            state_d = ptps_pkg::ST_WALK;
          end else if (adv_ok) begin
            state_d = ptps_pkg::ST_ADV_NXT;
          end else begin
            state_d = ptps_pkg::ST_DONE;
          end
        end
      end
      ptps_pkg::ST_WALK: begin
        if (sq_v_q && walk_stop) begin
          state_d = ptps_pkg::ST_DONE;
        end
      end
      ptps_pkg::ST_ADV_NXT: begin
        if (sq_v_q) begin
          state_d = ptps_pkg::ST_ADV_CUR;
        end
      end
      ptps_pkg::ST_ADV_CUR: begin
        if (sq_v_q) begin
          state_d = ptps_pkg::ST_DONE;
        end
      end
      ptps_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = ptps_pkg::ST_IDLE;
        end
      end
      default: state_d = ptps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin : datapath
    req_d       = req_q;
    res_stat_d  = res_stat_q;
    res_idx_d   = res_idx_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    iss_on_d    = iss_on_q;
    ref_x_d     = ref_x_q;
    ref_y_d     = ref_y_q;
    pt_x_d      = pt_x_q;
    pt_y_d      = pt_y_q;
    la2_d       = la2_q;
    best_d      = best_q;
    nxt_d       = nxt_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    ram_we      = 1'b0;
    ram_wdata   = {in_item_i.pos_x, in_item_i.pos_y};
    flush       = 1'b0;
    rd_tag_d    = iss_q;
    sq_tag_d    = rd_tag_q;

    if (iss_on_q) begin
      iss_d = iss_q + IDX_W'(1);
      if (iss_last || (state_q == ptps_pkg::ST_ADV_NXT) ||
          (state_q == ptps_pkg::ST_ADV_CUR)) begin
        iss_on_d = 1'b0;
      end
    end

    if (rd_v_q) begin
      pt_x_d = rd_x;
      pt_y_d = rd_y;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ptps_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_d      = in_item_i.req_type;
          ref_x_d    = in_item_i.pos_x;
          ref_y_d    = in_item_i.pos_y;
          la2_d      = in_item_i.lookahead * in_item_i.lookahead;
          res_idx_d  = '0;
          res_stat_d = ptps_pkg::STAT_OK;
          unique case (in_item_i.req_type)
            ptps_pkg::REQ_CLEAR: begin
              cnt_d = '0;
            end
            ptps_pkg::REQ_APPEND: begin
              if (cnt_q == CNT_W'(MAX_POINTS)) begin
                res_stat_d = ptps_pkg::STAT_FULL;
              end else begin
                ram_we = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            ptps_pkg::REQ_NEAREST, ptps_pkg::REQ_LOOKAHEAD: begin
              if (is_empty) begin
                res_stat_d = ptps_pkg::STAT_EMPTY;
              end else begin
                iss_d    = '0;
                iss_on_d = 1'b1;
              end
            end
            default: res_stat_d = ptps_pkg::STAT_OK;
          endcase
        end
      end
      ptps_pkg::ST_SCAN: begin
        if (sq_v_q) begin
          if (better) begin
            best_d = dist_sq;
            idx_d  = sq_tag_q;
          end
          if (tag_last) begin
            if (req_q == ptps_pkg::REQ_LOOKAHEAD) begin
              iss_d    = scan_idx;
              iss_on_d = 1'b1;
            end else if (adv_ok) begin
              iss_d    = scan_idx + IDX_W'(1);
              iss_on_d = 1'b1;
            end else begin
              res_idx_d = scan_idx;
            end
          end
        end
      end
      ptps_pkg::ST_WALK: begin
        if (sq_v_q && walk_stop) begin
          res_idx_d = sq_tag_q;
          iss_on_d  = 1'b0;
          flush     = 1'b1;
        end
      end
      ptps_pkg::ST_ADV_NXT: begin
        // next point becomes the reference so the second read yields the gap
        if (sq_v_q) begin
          nxt_d    = dist_sq;
          ref_x_d  = pt_x_q;
          ref_y_d  = pt_y_q;
          iss_d    = idx_q;
          iss_on_d = 1'b1;
        end
      end
      ptps_pkg::ST_ADV_CUR: begin
        if (sq_v_q) begin
          res_idx_d = (nxt_q < dist_sq) ? (idx_q + IDX_W'(1)) : idx_q;
        end
      end
      ptps_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.target_index = res_idx_ext[ptps_pkg::IDX_OUT_W-1:0];
          out_d.point_count  = cnt_ext[ptps_pkg::CNT_OUT_W-1:0];
          out_d.status       = res_stat_q;
        end
      end
      default: flush = 1'b1;
    endcase

    rd_v_d = iss_on_q && !flush;
    sq_v_d = rd_v_q && !flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptps_pkg::ST_IDLE;
      cnt_q       <= '0;
      iss_on_q    <= 1'b0;
      rd_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_on_q    <= iss_on_d;
      rd_v_q      <= rd_v_d;
      sq_v_q      <= sq_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_stat_q <= res_stat_d;
    res_idx_q  <= res_idx_d;
    iss_q      <= iss_d;
    rd_tag_q   <= rd_tag_d;
    sq_tag_q   <= sq_tag_d;
    sqx_q      <= sqx_d;
    sqy_q      <= sqy_d;
    ref_x_q    <= ref_x_d;
    ref_y_q    <= ref_y_d;
    pt_x_q     <= pt_x_d;
    pt_y_q     <= pt_y_d;
    la2_q      <= la2_d;
    best_q     <= best_d;
    nxt_q      <= nxt_d;
    idx_q      <= idx_d;
    out_q      <= out_d;
  end

endmodule

// File: hw/rtl/ptps_checker.sv
// port-level assertions for the path target point search block, with bind
`include "path_target_point_search_macros.svh"

module ptps_checker #(
  parameter int unsigned MAX_POINTS = ptps_pkg::MAX_POINTS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ptps_pkg::path_req_t in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ptps_pkg::path_rsp_t out_item_o
);

  localparam logic [31:0] MAX_EXT = 32'(MAX_POINTS);

  `PTPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result item changed or dropped while stalled")

  `PTPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "second item taken before the first was finished")

  `PTPS_ASSERT_NOW(a_empty_zero, out_valid_o && (out_item_o.status == ptps_pkg::STAT_EMPTY), (out_item_o.target_index == '0) && (out_item_o.point_count == '0), "empty path status with nonzero index or count")

  `PTPS_ASSERT_NOW(a_full_count, out_valid_o && (out_item_o.status == ptps_pkg::STAT_FULL), (out_item_o.target_index == '0) && (out_item_o.point_count == MAX_EXT[ptps_pkg::CNT_OUT_W-1:0]), "full path status with wrong count")

endmodule

bind path_target_point_search ptps_checker #(.MAX_POINTS(MAX_POINTS)) u_ptps_checker (.*);
